/* sv/lptc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lptc_pkg: shared types and constants of the line printer text canonicalizer
// Character codes, operation encoding between front and back, configuration
// record and counter helpers.
// ----------------------------------------------------------------------------
package lptc_pkg;

    localparam int CNT_BITS = 16;
    typedef logic [CNT_BITS-1:0] cnt_t;
    localparam cnt_t CNT_MAX = {CNT_BITS{1'b1}};

    // character codes
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_GRAVE   = 8'h60;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_VBAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    localparam cnt_t INDENT_COL = cnt_t'(8);
    localparam cnt_t TAB_STEP   = cnt_t'(8);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_UPPERCASE = 3'd0;
    localparam cfg_idx_t REG_INDENT    = 3'd1;
    localparam cfg_idx_t REG_EJECT     = 3'd2;
    localparam cfg_idx_t REG_LPP       = 3'd3;
    localparam cfg_idx_t REG_MAXCOL    = 3'd4;

    localparam logic [7:0] LPP_RESET    = 8'd60;
    localparam logic [7:0] MAXCOL_RESET = 8'd80;

    typedef enum logic [2:0] {
        OP_TAB,
        OP_LINE_END,
        OP_CR,
        OP_BS,
        OP_SPACE,
        OP_GLYPH
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] ch;     // glyph, or LF/FF for a line end
        logic       dash;   // overstrike the glyph with a dash
    } op_t;

    typedef struct packed {
        logic       indent_enable;
        logic       eject_enable;
        logic [7:0] lines_per_page;
        logic [7:0] max_columns;
    } back_cfg_t;

    typedef enum logic {
        BK_IDLE,
        BK_GLYPH
    } back_state_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        sat_inc = (v == CNT_MAX) ? v : v + cnt_t'(1);
    endfunction

endpackage
`default_nettype wire

/* sv/lptc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lptc_front: character classifier
// Fold case in uppercase mode and turn each character into one operation.
// ----------------------------------------------------------------------------
module lptc_front (
    input  wire logic          [7:0] ch,
    input  wire logic                uppercase_mode,
    output lptc_pkg::op_t            op
);

    logic [7:0] c;
    logic [7:0] base;

    always_comb
    begin
        c    = ch;
        base = 8'd0;
        if (uppercase_mode)
        begin
            if (ch >= lptc_pkg::CH_LOWER_A && ch <= lptc_pkg::CH_LOWER_Z)
            begin
                c = ch - lptc_pkg::CASE_FOLD;
            end
            else
            begin
                case (ch)
                    lptc_pkg::CH_LBRACE: base = lptc_pkg::CH_LPAREN;
                    lptc_pkg::CH_RBRACE: base = lptc_pkg::CH_RPAREN;
                    lptc_pkg::CH_GRAVE:  base = lptc_pkg::CH_QUOTE;
                    lptc_pkg::CH_VBAR:   base = lptc_pkg::CH_BANG;
                    lptc_pkg::CH_TILDE:  base = lptc_pkg::CH_CARET;
                    default:             base = 8'd0;
                endcase
            end
        end

        op.ch   = c;
        op.dash = 1'b0;
        if (base != 8'd0)
        begin
            op.kind = lptc_pkg::OP_GLYPH;
            op.ch   = base;
            op.dash = 1'b1;
        end
        else
        begin
            case (c)
                lptc_pkg::CH_TAB:   op.kind = lptc_pkg::OP_TAB;
                lptc_pkg::CH_LF:    op.kind = lptc_pkg::OP_LINE_END;
                lptc_pkg::CH_FF:    op.kind = lptc_pkg::OP_LINE_END;
                lptc_pkg::CH_CR:    op.kind = lptc_pkg::OP_CR;
                lptc_pkg::CH_BS:    op.kind = lptc_pkg::OP_BS;
                lptc_pkg::CH_SPACE: op.kind = lptc_pkg::OP_SPACE;
                default:            op.kind = lptc_pkg::OP_GLYPH;
            endcase
        end
    end

endmodule
`default_nettype wire

/* sv/lptc_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lptc_queue: two-entry operation queue
// Decouple the classifier from the back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module lptc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output      logic          push_ready,
    input  wire lptc_pkg::op_t push_op,
    output      logic          pop_valid,
    input  wire logic          pop,
    output      lptc_pkg::op_t pop_op
);

    lptc_pkg::op_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

/* sv/lptc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lptc_back: column tracker and printer sequencer
// Hold the column and line counters, carry out one operation at a time and
// emit printer beats through an output register.
// ----------------------------------------------------------------------------
module lptc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lptc_pkg::back_cfg_t cfg,
    input  wire logic                op_valid,
    output      logic                op_pop,
    input  wire lptc_pkg::op_t       op,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      logic          [7:0] out_char,
    output      logic          [7:0] repeat_res,
    output      logic                last
);

    lptc_pkg::back_state_t state_reg;
    lptc_pkg::back_state_t state_next;

    lptc_pkg::cnt_t l_reg;
    lptc_pkg::cnt_t l_next;
    logic [7:0]     p_reg;
    logic [7:0]     p_next;
    lptc_pkg::cnt_t lc_reg;
    lptc_pkg::cnt_t lc_next;
    logic [7:0]     gch_reg;
    logic [7:0]     gch_next;
    logic           dash_reg;
    logic           dash_next;

    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     out_char_reg;
    logic [7:0]     out_char_next;
    logic [7:0]     repeat_reg;
    logic [7:0]     repeat_next;
    logic           last_reg;
    logic           last_next;

    logic           out_free;
    logic           emit;
    logic [7:0]     e_char;
    logic [7:0]     e_rep;
    logic           e_last;
    logic           go;

    lptc_pkg::cnt_t          home_col;
    lptc_pkg::cnt_t          l_inc;
    lptc_pkg::cnt_t          l_dash;
    lptc_pkg::cnt_t          p_wide;
    lptc_pkg::cnt_t          maxc_wide;
    logic [lptc_pkg::CNT_BITS:0] tab_sum;
    lptc_pkg::cnt_t          tab_col;
    lptc_pkg::cnt_t          lc_inc;
    logic                    le_emit;
    logic                    le_ff;
    logic                    need_cr;
    logic                    prints;
    logic                    need_sp;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign repeat_res = repeat_reg;
    assign last       = last_reg;

    always_comb
    begin
        home_col  = cfg.indent_enable ? lptc_pkg::INDENT_COL : '0;
        l_inc     = lptc_pkg::sat_inc(l_reg);
        // logical column after printing one glyph and stepping back over it
        l_dash    = (l_reg == lptc_pkg::CNT_MAX) ? lptc_pkg::CNT_MAX - lptc_pkg::cnt_t'(1)
                                                 : l_reg;
        p_wide    = lptc_pkg::cnt_t'(p_reg);
        maxc_wide = lptc_pkg::cnt_t'(cfg.max_columns);
        tab_sum   = {1'b0, l_reg} + {1'b0, lptc_pkg::TAB_STEP};
        tab_col   = tab_sum[lptc_pkg::CNT_BITS] ? lptc_pkg::CNT_MAX
                                                : (tab_sum[lptc_pkg::CNT_BITS-1:0] & ~lptc_pkg::cnt_t'(7));
        lc_inc    = lptc_pkg::sat_inc(lc_reg);
        le_emit   = !cfg.eject_enable || (p_reg != 8'd0) || (lc_reg != '0);
        le_ff     = cfg.eject_enable && (lc_inc >= lptc_pkg::cnt_t'(cfg.lines_per_page));
        need_cr   = l_reg < p_wide;
        prints    = l_reg < maxc_wide;
        need_sp   = prints && (l_reg > p_wide);
    end

    always_comb
    begin
        state_next = state_reg;
        l_next     = l_reg;
        p_next     = p_reg;
        lc_next    = lc_reg;
        gch_next   = gch_reg;
        dash_next  = dash_reg;
        op_pop     = 1'b0;
        emit       = 1'b0;
        e_char     = lptc_pkg::CH_SPACE;
        e_rep      = 8'd1;
        e_last     = 1'b0;
        go         = 1'b0;

        case (state_reg)
            lptc_pkg::BK_IDLE:
            begin
                if (op_valid)
                begin
                    case (op.kind)
                        lptc_pkg::OP_TAB:
                        begin
                            op_pop = 1'b1;
                            l_next = tab_col;
                        end
                        lptc_pkg::OP_LINE_END:
                        begin
                            if (le_emit)
                            begin
                                emit   = 1'b1;
                                e_char = le_ff ? lptc_pkg::CH_FF : op.ch;
                                e_last = 1'b1;
                                if (out_free)
                                begin
                                    op_pop  = 1'b1;
                                    p_next  = 8'd0;
                                    // any form feed that goes out starts a new page
                                    lc_next = (le_ff || (op.ch == lptc_pkg::CH_FF)) ? '0
                                                                                    : lc_inc;
                                    l_next  = home_col;
                                end
                            end
                            else
                            begin
                                // blank page top: drop the line end
                                op_pop = 1'b1;
                                l_next = home_col;
                            end
                        end
                        lptc_pkg::OP_CR:
                        begin
                            op_pop = 1'b1;
                            l_next = home_col;
                        end
                        lptc_pkg::OP_BS:
                        begin
                            op_pop = 1'b1;
                            if (l_reg != '0)
                            begin
                                l_next = l_reg - lptc_pkg::cnt_t'(1);
                            end
                        end
                        lptc_pkg::OP_SPACE:
                        begin
                            op_pop = 1'b1;
                            l_next = l_inc;
                        end
                        lptc_pkg::OP_GLYPH:
                        begin
                            op_pop     = 1'b1;
                            gch_next   = op.ch;
                            dash_next  = op.dash;
                            state_next = lptc_pkg::BK_GLYPH;
                        end
                        default:
                        begin
                            op_pop = 1'b1;
                        end
                    endcase
                end
            end

            lptc_pkg::BK_GLYPH:
            begin
                if (need_cr)
                begin
                    // head is right of the text: return the carriage first
                    emit   = 1'b1;
                    e_char = lptc_pkg::CH_CR;
                    e_last = !(prints || (dash_reg && (l_dash < maxc_wide)));
                    go     = out_free;
                    if (go)
                    begin
                        p_next = 8'd0;
                    end
                end
                else if (need_sp)
                begin
                    emit   = 1'b1;
                    e_char = lptc_pkg::CH_SPACE;
                    e_rep  = l_reg[7:0] - p_reg;
                    go     = out_free;
                    if (go)
                    begin
                        p_next = l_reg[7:0];
                    end
                end
                else
                begin
                    if (prints)
                    begin
                        emit   = 1'b1;
                        e_char = gch_reg;
                        e_last = !dash_reg;
                    end
                    go = !prints || out_free;
                    if (go)
                    begin
                        if (prints)
                        begin
                            p_next = p_reg + 8'd1;
                        end
                        if (dash_reg)
                        begin
                            l_next    = l_dash;
                            gch_next  = lptc_pkg::CH_DASH;
                            dash_next = 1'b0;
                        end
                        else
                        begin
                            l_next     = l_inc;
                            state_next = lptc_pkg::BK_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = lptc_pkg::BK_IDLE;
            end
        endcase

        // output register: load when free, hold while the receiver stalls
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        repeat_next    = repeat_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = emit;
            out_char_next  = e_char;
            repeat_next    = e_rep;
            last_next      = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lptc_pkg::BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_reg         <= '0;
            p_reg         <= 8'd0;
            lc_reg        <= '0;
            dash_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            l_reg         <= l_next;
            p_reg         <= p_next;
            lc_reg        <= lc_next;
            dash_reg      <= dash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gch_reg      <= gch_next;
        out_char_reg <= out_char_next;
        repeat_reg   <= repeat_next;
        last_reg     <= last_next;
    end

endmodule
`default_nettype wire

/* sv/line_printer_text_canonicalizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_printer_text_canonicalizer: text to printer character stream
// Tracks logical column, print head column and page line count, and turns
// each text byte into zero to six printer beats.
// ----------------------------------------------------------------------------
// Usage:
//   in   (in_valid/in_ready, ch): one text byte per beat. The classifier
//        folds case and sorts the byte into an operation that enters a
//        two-entry queue; in_ready drops only while that queue is full.
//   out  (out_valid/out_ready, out_char, repeat_res, last): one printer
//        character per beat; a run of spaces is one beat with a count, and
//        last marks the final beat caused by an input byte. Bytes that only
//        move the column produce no beat.
//   cfg  (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes, always
//        ready; write only while the block is idle. Unknown indexes drop.
// Flow: an accepted byte waits in the queue; a line end's beat is loaded
//   straight into the output register, a glyph passes the glyph state first.
//   The back end takes one operation at a time: a column move is done on
//   dispatch, a line end once the output register is free, and a glyph
//   sends its beats in turn (carriage return, space run, glyph), again for
//   the dash of an overstrike, before the next operation is taken.
// Reset: counters clear, registers take their defaults (indent and eject on,
//   60 lines per page, 80 columns). When the receiver stalls, the output
//   register holds its beat, the back end waits and the queue fills.
// ----------------------------------------------------------------------------
module line_printer_text_canonicalizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic                     [7:0] ch,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic                     [7:0] out_char,
    output      logic                     [7:0] repeat_res,
    output      logic                           last,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [lptc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic                     [7:0] cfg_data
);

    // configuration registers
    logic       uppercase_reg;
    logic       indent_reg;
    logic       eject_reg;
    logic [7:0] lpp_reg;
    logic [7:0] maxcol_reg;

    lptc_pkg::op_t       front_op;
    lptc_pkg::op_t       q_op;
    logic                q_valid;
    logic                q_pop;
    lptc_pkg::back_cfg_t back_cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uppercase_reg <= 1'b0;
            indent_reg    <= 1'b1;
            eject_reg     <= 1'b1;
            lpp_reg       <= lptc_pkg::LPP_RESET;
            maxcol_reg    <= lptc_pkg::MAXCOL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lptc_pkg::REG_UPPERCASE: uppercase_reg <= cfg_data[0];
                lptc_pkg::REG_INDENT:    indent_reg    <= cfg_data[0];
                lptc_pkg::REG_EJECT:     eject_reg     <= cfg_data[0];
                lptc_pkg::REG_LPP:       lpp_reg       <= cfg_data;
                lptc_pkg::REG_MAXCOL:    maxcol_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        back_cfg.indent_enable  = indent_reg;
        back_cfg.eject_enable   = eject_reg;
        back_cfg.lines_per_page = lpp_reg;
        back_cfg.max_columns    = maxcol_reg;
    end

    // classify the incoming byte
    lptc_front u_front (
        .ch             (ch),
        .uppercase_mode (uppercase_reg),
        .op             (front_op)
    );

    // decouple the classifier from the sequencer
    lptc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_op    (front_op),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_op     (q_op)
    );

    // advance the counters and emit printer beats
    lptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (back_cfg),
        .op_valid   (q_valid),
        .op_pop     (q_pop),
        .op         (q_op),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .repeat_res (repeat_res),
        .last       (last)
    );

endmodule
`default_nettype wire
